// ===== rtl/gpd_pkg.sv =====
package gpd_pkg;

  // Register map, one 32-bit register per word address
  localparam int unsigned REG_ADDR_BITS = 4;
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_PEAK_THRESHOLD = 2'd2;

  localparam int unsigned APB_DATA_BITS  = 32;
  localparam int unsigned SIZE_BITS      = 12;
  localparam int unsigned THRESHOLD_BITS = 16;
  localparam int unsigned VALUE_BITS     = 16;
  localparam int unsigned COORD_BITS     = 11;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 12'd2048;
  localparam logic [SIZE_BITS-1:0] SIZE_MIN   = 12'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [VALUE_BITS-1:0] center_value;
    logic                  is_peak;
    logic                  last_in_frame;
  } result_t;

endpackage

// ===== rtl/gpd_line_store.sv =====
module gpd_line_store #(
  parameter int unsigned DEPTH     = 2048,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_BITS-1:0]     wr_data,
  output logic [DATA_BITS-1:0]     rd_data
);
  import gpd_pkg::*;

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] mem_q;
  logic [DATA_BITS-1:0] fwd_data;
  logic                 fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // A write to the entry being read lands at the same edge: take the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

// ===== rtl/grid_local_peak_detector.sv =====
// Channel   Handshake               Word
// --------  ----------------------  ------------------------------------------------
// in        in_valid / in_ready     flow_value, frame_start
// out       out_valid / out_ready   center_x, center_y, center_value, is_peak,
//                                   last_in_frame
// cfg       APB write, pready high  frame_width, frame_height, peak_threshold
//
// One word a cycle while the skid register is empty; a result is offered after its completing
// sample is taken, through line store read, window shift and neighbour compare into the output.
// The single-port-per-side line store sets the pace: one read and one write a cycle.
// Reset clears counters, window and handshake state; the line store needs no clear.
// A held result parks in a skid register; the input stalls only once that is full.
module grid_local_peak_detector #(
  parameter int unsigned MAX_WIDTH   = 2048,
  parameter int unsigned MAX_HEIGHT  = 2048,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gpd_pkg::REG_ADDR_BITS-1:0]   paddr,
  input  logic [gpd_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [gpd_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  // input samples
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gpd_pkg::VALUE_BITS-1:0]      flow_value,
  input  logic                                frame_start,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gpd_pkg::COORD_BITS-1:0]      center_x,
  output logic [gpd_pkg::COORD_BITS-1:0]      center_y,
  output logic [gpd_pkg::VALUE_BITS-1:0]      center_value,
  output logic                                is_peak,
  output logic                                last_in_frame
);
  import gpd_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned WCMP = (CW + 1 > SIZE_BITS) ? CW + 1 : SIZE_BITS;
  localparam int unsigned HCMP = (RW + 1 > SIZE_BITS) ? RW + 1 : SIZE_BITS;
  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned TW   = (SB > THRESHOLD_BITS) ? SB : THRESHOLD_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SIZE_BITS-1:0]      frame_width;
  logic [SIZE_BITS-1:0]      frame_height;
  logic [THRESHOLD_BITS-1:0] peak_threshold;
  logic                      cfg_write;
  logic [1:0]                cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= SIZE_RESET;
      frame_height   <= SIZE_RESET;
      peak_threshold <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    frame_width    <= pwdata[SIZE_BITS-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= pwdata[SIZE_BITS-1:0];
        REG_PEAK_THRESHOLD: peak_threshold <= pwdata[THRESHOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_FRAME_WIDTH:    prdata = APB_DATA_BITS'(frame_width);
      REG_FRAME_HEIGHT:   prdata = APB_DATA_BITS'(frame_height);
      REG_PEAK_THRESHOLD: prdata = APB_DATA_BITS'(peak_threshold);
      default:            prdata = '0;
    endcase
  end

  // Clamp the frame size to at least SIZE_MIN and at most MAX_WIDTH by MAX_HEIGHT
  logic [WCMP-1:0] width_used;
  logic [HCMP-1:0] height_used;

  always_comb begin
    if (frame_width < SIZE_MIN) begin
      width_used = WCMP'(SIZE_MIN);
    end else if (WCMP'(frame_width) > WCMP'(MAX_WIDTH)) begin
      width_used = WCMP'(MAX_WIDTH);
    end else begin
      width_used = WCMP'(frame_width);
    end
    if (frame_height < SIZE_MIN) begin
      height_used = HCMP'(SIZE_MIN);
    end else if (HCMP'(frame_height) > HCMP'(MAX_HEIGHT)) begin
      height_used = HCMP'(MAX_HEIGHT);
    end else begin
      height_used = HCMP'(frame_height);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline advance: everything moves while the skid is empty
  // ---------------------------------------------------------------------------
  logic skid_valid;
  logic advance;
  logic in_accept;

  assign advance   = !skid_valid;
  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Stage 0: position counters, line store read
  // ---------------------------------------------------------------------------
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic          col_wrap;
  logic          row_wrap;
  logic          emit_cur;
  logic [SB-1:0] sample_in;

  assign col_cur   = frame_start ? '0 : column_count;
  assign row_cur   = frame_start ? '0 : row_count;
  assign col_wrap  = (WCMP'(col_cur) + WCMP'(1)) >= width_used;
  assign row_wrap  = (HCMP'(row_cur) + HCMP'(1)) >= height_used;
  assign emit_cur  = (col_cur >= CW'(2)) && (row_cur >= RW'(2));
  assign sample_in = SB'(flow_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_cur + RW'(1);
      end else begin
        column_count <= col_cur + CW'(1);
        row_count    <= row_cur;
      end
    end
  end

  // Stage 1 registers: the word, its column and what its result will carry
  logic          s1_valid;
  logic [CW-1:0] s1_col;
  logic [SB-1:0] s1_sample;
  logic          s1_emit;
  result_t       s1_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col                <= col_cur;
      s1_sample             <= sample_in;
      s1_emit               <= emit_cur;
      s1_meta.center_x      <= COORD_BITS'(col_cur - CW'(1));
      s1_meta.center_y      <= COORD_BITS'(row_cur - RW'(1));
      s1_meta.center_value  <= '0;
      s1_meta.is_peak       <= 1'b0;
      s1_meta.last_in_frame <= col_wrap && row_wrap;
    end
  end

  // Each entry holds {row y-2, row y-1} for its column
  logic [2*SB-1:0] line_rd;
  logic [2*SB-1:0] line_wr;
  logic            line_wr_en;
  logic [SB-1:0]   top_px;
  logic [SB-1:0]   mid_px;

  assign top_px     = line_rd[2*SB-1:SB];
  assign mid_px     = line_rd[SB-1:0];
  assign line_wr    = {mid_px, s1_sample};
  assign line_wr_en = advance && s1_valid;

  gpd_line_store #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (2 * SB)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (col_cur),
    .wr_en   (line_wr_en),
    .wr_addr (s1_col),
    .wr_data (line_wr),
    .rd_data (line_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: window shift; the window then belongs to the word in stage 2
  // ---------------------------------------------------------------------------
  logic [SB-1:0] win [3][3];
  logic          s2_valid;
  logic          s2_emit;
  result_t       s2_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (line_wr_en) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= top_px;
      win[1][2] <= mid_px;
      win[2][2] <= s1_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (line_wr_en) begin
      s2_emit <= s1_emit;
      s2_meta <= s1_meta;
    end
  end

  // Neighbour compare: ties still count as a peak
  logic    neighbour_above;
  logic    peak_now;
  logic    push;
  result_t result_now;

  always_comb begin
    neighbour_above = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1) && (win[r][c] > win[1][1])) begin
          neighbour_above = 1'b1;
        end
      end
    end
  end

  assign peak_now = (TW'(win[1][1]) >= TW'(peak_threshold)) && !neighbour_above;
  assign push     = advance && s2_valid && s2_emit;

  always_comb begin
    result_now              = s2_meta;
    result_now.center_value = VALUE_BITS'(win[1][1]);
    result_now.is_peak      = peak_now;
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid entry behind it
  // ---------------------------------------------------------------------------
  result_t out_word;
  result_t skid_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (push) begin
        out_word <= result_now;
      end
    end else if (push) begin
      skid_word <= result_now;
    end
  end

  assign center_x      = out_word.center_x;
  assign center_y      = out_word.center_y;
  assign center_value  = out_word.center_value;
  assign is_peak       = out_word.is_peak;
  assign last_in_frame = out_word.last_in_frame;

endmodule

// ===== tb/gpd_peak_checker.sv =====
module gpd_peak_checker #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gpd_pkg::REG_ADDR_BITS-1:0]  paddr,
  input  logic [gpd_pkg::APB_DATA_BITS-1:0]  pwdata,
  input  logic                               pready,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [gpd_pkg::VALUE_BITS-1:0]     flow_value,
  input  logic                               frame_start,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [gpd_pkg::COORD_BITS-1:0]     center_x,
  input  logic [gpd_pkg::COORD_BITS-1:0]     center_y,
  input  logic [gpd_pkg::VALUE_BITS-1:0]     center_value,
  input  logic                               is_peak,
  input  logic                               last_in_frame,
  output int unsigned                        results_due,
  output int unsigned                        fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import gpd_pkg::*;

  localparam int unsigned PRINT_CAP = 40;

  // line stores: previous row and the one before it
  logic [VALUE_BITS-1:0]     prev_row  [MAX_WIDTH] = '{default: '0};
  logic [VALUE_BITS-1:0]     older_row [MAX_WIDTH] = '{default: '0};
  logic [VALUE_BITS-1:0]     win [3][3];
  int unsigned               col_pos;
  int unsigned               row_pos;
  logic [SIZE_BITS-1:0]      width_reg;
  logic [SIZE_BITS-1:0]      height_reg;
  logic [THRESHOLD_BITS-1:0] thresh_reg;
  result_t                   peaks_due [$];
  int unsigned               mismatches = 0;

  assign fail_count = mismatches;

  function automatic int unsigned clamp_dim(input logic [SIZE_BITS-1:0] raw,
                                            input int unsigned limit);
    if (raw < SIZE_MIN) return SIZE_MIN;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // Place one sample, slide the window, and give the centre verdict if interior
  function automatic bit predict_peak(input logic [VALUE_BITS-1:0] value,
                                      input logic start, output result_t res);
    int unsigned          w_eff;
    int unsigned          h_eff;
    int unsigned          x;
    logic [VALUE_BITS-1:0] upper_v;
    logic [VALUE_BITS-1:0] mid_v;
    logic [VALUE_BITS-1:0] ctr;
    bit                   peak;
    bit                   fired;
    w_eff = clamp_dim(width_reg, MAX_WIDTH);
    h_eff = clamp_dim(height_reg, MAX_HEIGHT);
    fired = 1'b0;
    res   = '0;
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    x = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    upper_v      = older_row[x];
    mid_v        = prev_row[x];
    older_row[x] = mid_v;
    prev_row[x]  = value;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper_v;
    win[1][2] = mid_v;
    win[2][2] = value;
    if (col_pos >= 2 && row_pos >= 2) begin
      ctr  = win[1][1];
      peak = (ctr >= thresh_reg);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (!(r == 1 && c == 1) && win[r][c] > ctr) peak = 1'b0;
        end
      end
      res.center_x      = COORD_BITS'(col_pos - 1);
      res.center_y      = COORD_BITS'(row_pos - 1);
      res.center_value  = ctr;
      res.is_peak       = peak;
      res.last_in_frame = (col_pos + 1 >= w_eff) && (row_pos + 1 >= h_eff);
      fired = 1'b1;
    end
    if (col_pos + 1 >= w_eff) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h_eff) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return fired;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t fresh;
    result_t want;
    if (rst) begin
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
      thresh_reg = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win[r][c] = '0;
      end
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[REG_ADDR_BITS-1:2])
          REG_FRAME_WIDTH:    width_reg  = pwdata[SIZE_BITS-1:0];
          REG_FRAME_HEIGHT:   height_reg = pwdata[SIZE_BITS-1:0];
          REG_PEAK_THRESHOLD: thresh_reg = pwdata[THRESHOLD_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (predict_peak(flow_value, frame_start, fresh)) peaks_due = {peaks_due, fresh};
      end
      if (out_valid && out_ready) begin
        if (peaks_due.size() == 0) begin
          report_mismatch("result with nothing pending", {center_y, center_x}, '0);
        end else begin
          want = peaks_due.pop_front();
          if (center_x !== want.center_x)
            report_mismatch("center_x", center_x, want.center_x);
          if (center_y !== want.center_y)
            report_mismatch("center_y", center_y, want.center_y);
          if (center_value !== want.center_value)
            report_mismatch("center_value", center_value, want.center_value);
          if (is_peak !== want.is_peak)
            report_mismatch("is_peak", is_peak, want.is_peak);
          if (last_in_frame !== want.last_in_frame)
            report_mismatch("last_in_frame", last_in_frame, want.last_in_frame);
        end
      end
    end
    results_due <= peaks_due.size();
  end

endmodule

// ===== tb/grid_local_peak_detector_test.sv =====
module grid_local_peak_detector_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gpd_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 8;
  // results are registered behind the line store read and window shift; allow a comfortable margin
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_WORDS = 1470;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_DIM      = 2048;
  localparam int unsigned DIRECTED_WORDS = 20;

  // Hand-built 5x4 frame, threshold 0x8000: two tied centres that are both
  // peaks, one just under the threshold beside a full-scale neighbour, and
  // centres beaten by a neighbour. The bottom-right interior pixel closes it.
  localparam logic [VALUE_BITS-1:0] DIRECTED_MAP [DIRECTED_WORDS] = '{
    16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'hFFFF,
    16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF,
    16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
    16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000
  };

  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [REG_ADDR_BITS-1:0] paddr       = '0;
  logic [APB_DATA_BITS-1:0] pwdata      = '0;
  logic                     in_valid    = 1'b0;
  logic [VALUE_BITS-1:0]    flow_value  = '0;
  logic                     frame_start = 1'b0;
  logic                     out_ready   = 1'b0;

  wire [APB_DATA_BITS-1:0]  prdata;
  wire                      pready;
  wire                      in_ready;
  wire                      out_valid;
  wire [COORD_BITS-1:0]     center_x;
  wire [COORD_BITS-1:0]     center_y;
  wire [VALUE_BITS-1:0]     center_value;
  wire                      is_peak;
  wire                      last_in_frame;

  int unsigned              results_due;
  int unsigned              fail_count;
  int unsigned              cycle_count   = 0;
  int unsigned              random_words  = 0;
  int unsigned              hold_requests = 0;
  bit                       gaps_on       = 1'b1;
  logic [THRESHOLD_BITS-1:0] cur_thresh   = '0;

  always #HALF_PERIOD clk = ~clk;

  grid_local_peak_detector u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .flow_value   (flow_value),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_value (center_value),
    .is_peak      (is_peak),
    .last_in_frame(last_in_frame)
  );

  gpd_peak_checker u_peak_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .flow_value   (flow_value),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_value (center_value),
    .is_peak      (is_peak),
    .last_in_frame(last_in_frame),
    .results_due  (results_due),
    .fail_count   (fail_count)
  );

  // Watchdog: abandon the run if it drags on far past any correct schedule
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL grid_local_peak_detector");
      $finish;
    end
  end

  // Result side: stall at random, and serve each long hold-off that the
  // stimulus asks for, counting the cycles here so the sender never waits on it
  initial begin : result_sink
    int unsigned served;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= !(gaps_on && $urandom_range(99) < 9);
    end
  end

  // Clamp a raw size register the way the block interprets it
  function automatic int unsigned fit(input int unsigned raw);
    return (raw < 3) ? 3 : ((raw > MAX_DIM) ? MAX_DIM : raw);
  endfunction

  // Lean towards small values, full scale and the threshold's neighbourhood
  // so that ties and near misses turn up often
  function automatic logic [VALUE_BITS-1:0] pick_flow();
    case ($urandom_range(9))
      0, 1, 2: return VALUE_BITS'($urandom_range(3));
      3:       return 16'hFFFF;
      4:       return cur_thresh + VALUE_BITS'($urandom_range(2)) - 16'd1;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Two-phase register write; drop the select in the cycle before returning
  task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_sizes(input int unsigned w_raw, input int unsigned h_raw,
                            input logic [THRESHOLD_BITS-1:0] thr);
    reg_write(REG_FRAME_WIDTH, APB_DATA_BITS'(w_raw));
    reg_write(REG_FRAME_HEIGHT, APB_DATA_BITS'(h_raw));
    reg_write(REG_PEAK_THRESHOLD, APB_DATA_BITS'(thr));
    cur_thresh = thr;
  endtask

  // Offer one word and hold it until the block takes it
  task automatic send_word(input logic [VALUE_BITS-1:0] value, input logic start);
    while (gaps_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    flow_value  <= value;
    frame_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // One raster frame of random content. Unless clean, now and then cut it short or drop a
  // stray restart inside, and unless clean or lead_in, leave out the leading start mark.
  task automatic send_frame(input int unsigned cols, input int unsigned rows,
                            input bit clean, input bit lead_in);
    int unsigned total;
    int unsigned stop;
    bit          lead;
    total = cols * rows;
    stop  = (!clean && $urandom_range(9) == 0) ? $urandom_range(1, total - 1) : total;
    lead  = clean || lead_in || ($urandom_range(4) != 0);
    for (int unsigned i = 0; i < stop; i++) begin
      send_word(pick_flow(), (i == 0 && lead) || (!clean && $urandom_range(49) == 0));
      if (!clean) random_words++;
    end
  endtask

  // Stop sending, wait for every pending result, then let the pipeline empty
  task automatic settle();
    in_valid    <= 1'b0;
    frame_start <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned           w_raw;
    int unsigned           h_raw;
    int unsigned           frames;
    int unsigned           phase;
    logic [THRESHOLD_BITS-1:0] thr;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frame, then a restart in the middle of a row
    load_sizes(5, 4, 16'h8000);
    for (int i = 0; i < DIRECTED_WORDS; i++) send_word(DIRECTED_MAP[i], i == 0);
    send_word(16'h1234, 1'b0);
    send_word(16'hEDCB, 1'b0);
    send_word(16'hFFFF, 1'b1);
    send_word(16'h0000, 1'b0);
    send_word(16'h5555, 1'b0);
    settle();

    // Medium frame with no idling on either side
    gaps_on <= 1'b0;
    load_sizes(40, 6, THRESHOLD_BITS'($urandom));
    send_frame(40, 6, 1'b1, 1'b1);
    settle();
    gaps_on <= 1'b1;

    // Tall narrow frame, the width reached through a zero write
    load_sizes(0, 40, '0);
    send_frame(3, 40, 1'b1, 1'b1);
    settle();

    // Over-range height clamps to the full height, so nothing here closes the
    // frame; run a dozen rows and leave the rest to the next start mark
    load_sizes(8, 12'hFFF, 16'h0100);
    for (int unsigned i = 0; i < 96; i++) send_word(pick_flow(), i == 0);
    settle();

    // Random phases of small frames under fresh settings each time
    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      w_raw  = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
      h_raw  = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
      frames = $urandom_range(1, 4);
      case ($urandom_range(3))
        0:       thr = '0;
        1:       thr = 16'hFFFF;
        2:       thr = THRESHOLD_BITS'($urandom_range(4));
        default: thr = THRESHOLD_BITS'($urandom);
      endcase
      // dense frames behind a long receiver hold-off so the block backs up
      if (phase == 2) begin
        w_raw  = 6;
        h_raw  = 6;
        frames = 4;
        hold_requests <= hold_requests + 1;
      end
      load_sizes(w_raw, h_raw, thr);
      for (int unsigned f = 0; f < frames; f++)
        send_frame(fit(w_raw), fit(h_raw), 1'b0, f == 0);
      settle();
      phase++;
    end

    if (fail_count == 0 && results_due == 0) begin
      $display("PASS grid_local_peak_detector");
    end else begin
      $display("FAIL grid_local_peak_detector");
    end
    $finish;
  end

endmodule

// ===== grid_local_peak_detector.f =====
rtl/gpd_pkg.sv
rtl/gpd_line_store.sv
rtl/grid_local_peak_detector.sv
tb/gpd_peak_checker.sv
tb/grid_local_peak_detector_test.sv
